// ===== rtl/core/pwb_pkg.sv =====
// Shared types and constants for the percentile white balance block.
package pwb_pkg;

    localparam int BINS = 256;
    localparam int CHANNELS = 3;
    localparam int BIN_W = $clog2(BINS);
    localparam int DEF_MAX_PIXELS_LOG2 = 24;
    localparam int PERMILLE_W = 10;
    localparam logic [PERMILLE_W-1:0] PERMILLE = 10'd1000;
    localparam int DISCARD_W = 9;
    localparam logic [DISCARD_W-1:0] DISCARD_RESET = 9'd50;
    localparam int PIX_W = 8;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 72;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_COUNT  = 2'd1,
        ACT_LIMITS = 2'd2,
        ACT_MAP    = 2'd3
    } action_t;

    typedef struct packed {
        action_t action;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_GOAL,
        ST_SCAN,
        ST_MAP_SETUP,
        ST_MAP_DIV,
        ST_EMIT
    } back_state_t;

    typedef struct packed {
        logic pop_ready;
        logic mem_we;
        logic emit;
    } back_ctrl_t;

endpackage

// ===== rtl/core/percentile_white_balance.sv =====
// Top level of the percentile white balance block.
//
// Input beats on the s_ channel carry an action in s_tuser and one RGB pixel in
// s_tdata. A clear beat empties the three 256-bin histograms, a count beat adds the
// pixel to them, a limits beat computes new per-channel clamp limits and returns
// one result beat, and a map beat returns the stretched pixel as one result beat.
// Results leave on the m_ channel; m_tuser is high for a limits report.
// The discard fraction in thousandths is to be written on the cfg_ channel only while
// idle; the user is bound by this, as the block does not enforce it. Beats pass a
// two-entry queue; the execution side takes one command at a time. A count is a
// read-modify-write of the bin memories. A map runs the 8-step divider of each
// channel. A limits beat walks over all 256 bins. A clear sweeps over every bin
// and writes it to zero.
// After reset the same clearing sweep runs and s_tready stays low.
// Reset sets the discard fraction to 50, low limits to 0 and high limits to 255.
// A stalled receiver holds the result register; further commands then wait.
module percentile_white_balance #(
    parameter int MAX_PIXELS_LOG2 = pwb_pkg::DEF_MAX_PIXELS_LOG2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pwb_pkg::IN_DATA_W-1:0]  s_tdata,  // red_in, green_in, blue_in
    input  logic [1:0]                     s_tuser,  // action
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // red_out, green_out, blue_out, red_low, red_high, green_low, green_high,
    // blue_low, blue_high
    output logic [pwb_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tuser,  // is_limits
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pwb_pkg::DISCARD_W-1:0]  cfg_data
);
    import pwb_pkg::*;

    logic init_done;
    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;
    logic [DISCARD_W-1:0] discard;

    pwb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (init_done),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .discard    (discard)
    );

    pwb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    pwb_back #(
        .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .discard   (discard),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .init_done (init_done),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTH
    a_limits_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[23:0] == 24'd0))
        else $error("limits report carries pixel data");

    a_pixel_no_limits: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata[71:24] == 48'd0))
        else $error("mapped pixel carries limit data");

    a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        !init_done |-> !(s_tvalid && s_tready))
        else $error("beat accepted during clearing sweep");
`endif

endmodule

// ===== rtl/core/pwb_front.sv =====
// Input side: accepts beats, decodes the action and holds the discard register.
module pwb_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          enable,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pwb_pkg::IN_DATA_W-1:0] s_tdata,  // red, green, blue
    input  logic [1:0]                    s_tuser,  // action
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pwb_pkg::DISCARD_W-1:0] cfg_data,
    output logic                          push_valid,
    input  logic                          push_ready,
    output pwb_pkg::cmd_t                 push_cmd,
    output logic [pwb_pkg::DISCARD_W-1:0] discard
);
    import pwb_pkg::*;

    logic [DISCARD_W-1:0] discard_reg;

    assign cfg_ready = 1'b1;
    assign discard = discard_reg;
    assign s_tready = enable & push_ready;
    assign push_valid = enable & s_tvalid;

    always_comb
    begin
        push_cmd.action = action_t'(s_tuser);
        push_cmd.red = s_tdata[7:0];
        push_cmd.green = s_tdata[15:8];
        push_cmd.blue = s_tdata[23:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discard_reg <= DISCARD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            discard_reg <= cfg_data;
        end
    end

endmodule

// ===== rtl/core/pwb_queue.sv =====
// Two-entry command queue between the front and the back.
module pwb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  pwb_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output pwb_pkg::cmd_t pop_cmd
);
    import pwb_pkg::*;

    cmd_t entry_reg [QUEUE_DEPTH];
    logic [1:0] count_reg;
    logic wr_ptr_reg;
    logic rd_ptr_reg;
    logic do_push;
    logic do_pop;

    assign push_ready = (count_reg != 2'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != 2'd0);
    assign pop_cmd = entry_reg[rd_ptr_reg];
    assign do_push = push_valid & push_ready;
    assign do_pop = pop_valid & pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/core/pwb_back.sv =====
// Execution side: histogram memories, limit scan, divider and result register.
module pwb_back #(
    parameter int MAX_PIXELS_LOG2 = pwb_pkg::DEF_MAX_PIXELS_LOG2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [pwb_pkg::DISCARD_W-1:0]  discard,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  pwb_pkg::cmd_t                  pop_cmd,
    output logic                           init_done,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pwb_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tuser
);
    import pwb_pkg::*;

    localparam int CW = MAX_PIXELS_LOG2;
    localparam int GW = CW + PERMILLE_W;

    logic [CW-1:0] hist_mem [CHANNELS][BINS];
    logic [CW-1:0] rd_data_reg [CHANNELS];
    logic [BIN_W-1:0] rd_addr [CHANNELS];
    logic [BIN_W-1:0] wr_addr [CHANNELS];
    logic [CW-1:0] wr_data [CHANNELS];

    back_state_t state_reg;
    back_state_t state_next;
    back_ctrl_t ctrl;
    cmd_t cmd_reg;
    logic init_done_reg;
    logic [BIN_W:0] addr_reg;
    logic [CW-1:0] total_reg;
    logic [PIX_W-1:0] lo_reg [CHANNELS];
    logic [PIX_W-1:0] hi_reg [CHANNELS];
    logic [GW-1:0] low_goal_reg;
    logic [GW-1:0] high_goal_reg;
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic [CW-1:0] cum_reg [CHANNELS];
    logic [GW-1:0] prod_reg [CHANNELS];
    logic [BIN_W:0] lo_cnt_reg [CHANNELS];
    logic [BIN_W:0] hi_cnt_reg [CHANNELS];
    logic [15:0] rem_reg [CHANNELS];
    logic [14:0] dsh_reg [CHANNELS];
    logic [PIX_W-1:0] quot_reg [CHANNELS];
    logic flat_reg [CHANNELS];
    logic inv_reg [CHANNELS];
    logic [2:0] step_reg;
    logic m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic m_user_reg;

    logic [PIX_W-1:0] pix [CHANNELS];
    logic [PIX_W-1:0] lo_new [CHANNELS];
    logic [PIX_W-1:0] hi_new [CHANNELS];
    logic [PIX_W-1:0] map_out [CHANNELS];
    logic [PIX_W-1:0] clamp_x [CHANNELS];
    logic [PIX_W-1:0] offset [CHANNELS];
    logic total_full;
    logic scan_done;
    logic out_free;

    assign init_done = init_done_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign m_tuser = m_user_reg;
    assign pop_ready = ctrl.pop_ready;
    assign pix[0] = cmd_reg.red;
    assign pix[1] = cmd_reg.green;
    assign pix[2] = cmd_reg.blue;
    assign total_full = &total_reg;
    assign scan_done = addr_reg[BIN_W] & ~v1_reg & ~v2_reg & ~v3_reg;
    assign out_free = ~m_valid_reg | m_tready;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            rd_addr[c] = (state_reg == ST_SCAN) ? addr_reg[BIN_W-1:0] : pix[c];
            wr_addr[c] = (state_reg == ST_CLEAR) ? addr_reg[BIN_W-1:0] : pix[c];
            wr_data[c] = (state_reg == ST_CLEAR) ? '0 : rd_data_reg[c] + CW'(1);
            lo_new[c] = lo_cnt_reg[c][BIN_W] ? PIX_W'(BINS - 1) : lo_cnt_reg[c][BIN_W-1:0];
            hi_new[c] = (hi_cnt_reg[c] < (BIN_W + 1)'(BINS - 1)) ? hi_cnt_reg[c][BIN_W-1:0]
                                                              : PIX_W'(hi_cnt_reg[c] - 9'd1);
            map_out[c] = flat_reg[c] ? (inv_reg[c] ? 8'd255 : 8'd0) : quot_reg[c];
            clamp_x[c] = (pix[c] < lo_reg[c]) ? lo_reg[c] : pix[c];
            clamp_x[c] = (clamp_x[c] > hi_reg[c]) ? hi_reg[c] : clamp_x[c];
            offset[c] = clamp_x[c] - lo_reg[c];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (&addr_reg[BIN_W-1:0])
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    unique case (pop_cmd.action)
                        ACT_CLEAR:  state_next = ST_CLEAR;
                        ACT_COUNT:  state_next = ST_CNT_RD;
                        ACT_LIMITS: state_next = ST_GOAL;
                        ACT_MAP:    state_next = ST_MAP_SETUP;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CNT_RD:    state_next = ST_CNT_WR;
            ST_CNT_WR:    state_next = ST_IDLE;
            ST_GOAL:      state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_MAP_SETUP: state_next = ST_MAP_DIV;
            ST_MAP_DIV:
            begin
                if (step_reg == 3'd0)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl.pop_ready = (state_reg == ST_IDLE);
        ctrl.mem_we = (state_reg == ST_CLEAR) || ((state_reg == ST_CNT_WR) && !total_full);
        ctrl.emit = (state_reg == ST_EMIT) && out_free;
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            rd_data_reg[c] <= hist_mem[c][rd_addr[c]];
            if (ctrl.mem_we)
            begin
                hist_mem[c][wr_addr[c]] <= wr_data[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.pop_ready && pop_valid)
        begin
            cmd_reg <= pop_cmd;
        end
        for (int c = 0; c < CHANNELS; c++)
        begin
            unique case (state_reg)
                ST_GOAL:
                begin
                    cum_reg[c] <= '0;
                    lo_cnt_reg[c] <= '0;
                    hi_cnt_reg[c] <= '0;
                end
                ST_SCAN:
                begin
                    if (v1_reg)
                    begin
                        cum_reg[c] <= cum_reg[c] + rd_data_reg[c];
                    end
                    if (v2_reg)
                    begin
                        prod_reg[c] <= GW'(cum_reg[c]) * GW'(PERMILLE);
                    end
                    if (v3_reg)
                    begin
                        lo_cnt_reg[c] <= lo_cnt_reg[c] + (BIN_W + 1)'(prod_reg[c] < low_goal_reg);
                        hi_cnt_reg[c] <= hi_cnt_reg[c]
                                         + (BIN_W + 1)'(prod_reg[c] <= high_goal_reg);
                    end
                end
                ST_MAP_SETUP:
                begin
                    flat_reg[c] <= (lo_reg[c] >= hi_reg[c]);
                    inv_reg[c] <= (lo_reg[c] > hi_reg[c]);
                    rem_reg[c] <= {offset[c], 8'd0} - 16'(offset[c]);
                    dsh_reg[c] <= {PIX_W'(hi_reg[c] - lo_reg[c]), 7'd0};
                    quot_reg[c] <= '0;
                end
                ST_MAP_DIV:
                begin
                    if (rem_reg[c] >= 16'(dsh_reg[c]))
                    begin
                        rem_reg[c] <= rem_reg[c] - 16'(dsh_reg[c]);
                        quot_reg[c] <= {quot_reg[c][PIX_W-2:0], 1'b1};
                    end
                    else
                    begin
                        quot_reg[c] <= {quot_reg[c][PIX_W-2:0], 1'b0};
                    end
                    dsh_reg[c] <= dsh_reg[c] >> 1;
                end
                default:
                begin
                end
            endcase
        end
        if (state_reg == ST_GOAL)
        begin
            low_goal_reg <= GW'(discard) * GW'(total_reg);
            high_goal_reg <= GW'(PERMILLE - PERMILLE_W'(discard)) * GW'(total_reg);
        end
        if (ctrl.emit)
        begin
            m_user_reg <= (cmd_reg.action == ACT_LIMITS);
            if (cmd_reg.action == ACT_LIMITS)
            begin
                m_data_reg <= {hi_new[2], lo_new[2], hi_new[1], lo_new[1],
                               hi_new[0], lo_new[0], 24'd0};
            end
            else
            begin
                m_data_reg <= {48'd0, map_out[2], map_out[1], map_out[0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            init_done_reg <= 1'b0;
            addr_reg <= '0;
            total_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            step_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                lo_reg[c] <= '0;
                hi_reg[c] <= PIX_W'(BINS - 1);
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    addr_reg <= addr_reg + (BIN_W + 1)'(1);
                    total_reg <= '0;
                    if (&addr_reg[BIN_W-1:0])
                    begin
                        init_done_reg <= 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    addr_reg <= '0;
                end
                ST_CNT_WR:
                begin
                    if (!total_full)
                    begin
                        total_reg <= total_reg + CW'(1);
                    end
                end
                ST_GOAL:
                begin
                    addr_reg <= '0;
                    v1_reg <= 1'b0;
                    v2_reg <= 1'b0;
                    v3_reg <= 1'b0;
                end
                ST_SCAN:
                begin
                    v1_reg <= ~addr_reg[BIN_W];
                    v2_reg <= v1_reg;
                    v3_reg <= v2_reg;
                    if (!addr_reg[BIN_W])
                    begin
                        addr_reg <= addr_reg + (BIN_W + 1)'(1);
                    end
                end
                ST_MAP_SETUP:
                begin
                    step_reg <= 3'd7;
                end
                ST_MAP_DIV:
                begin
                    step_reg <= step_reg - 3'd1;
                end
                ST_EMIT:
                begin
                    if (ctrl.emit && (cmd_reg.action == ACT_LIMITS))
                    begin
                        for (int c = 0; c < CHANNELS; c++)
                        begin
                            lo_reg[c] <= lo_new[c];
                            hi_reg[c] <= hi_new[c];
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (ctrl.emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule
